// ----- src/dnle_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS name label encoder package
// Shared constants, payload types, the command passed from the front to the
// back, and the state type of the back sequencer.
// ----------------------------------------------------------------------------
package dnle_pkg;

	localparam int MAX_LABEL = 62;
	localparam int CNT_W     = $clog2(MAX_LABEL + 1);
	localparam int BANKS     = 2;
	localparam int BANK_W    = $clog2(BANKS);
	localparam int ADDR_W    = BANK_W + CNT_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] CHAR_DOT  = 8'd46;
	localparam logic [7:0] CHAR_NUL  = 8'd0;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_name;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       label_too_long;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  len;
		logic              ovf;
		logic              last;
		logic [BANK_W-1:0] bank;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} release_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_RD,
		S_WR,
		S_TERM
	} back_state_t;

endpackage

// ----- src/dnle_ram.sv -----
// ----------------------------------------------------------------------------
// Label buffer RAM
// Two banks of label characters, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dnle_ram
	import dnle_pkg::*;
(
	input  logic              clk,
	input  ram_wr_t           wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/dnle_cmdq.sv -----
// ----------------------------------------------------------------------------
// Command queue
// Short queue of flush commands between the front and the back.
// ----------------------------------------------------------------------------
module dnle_cmdq
	import dnle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic q_full,
	input  logic pop,
	output logic q_empty,
	output cmd_t head
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign q_full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_push = push && !q_full;
	assign do_pop  = pop && !q_empty;
	assign head    = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
		end
	end

endmodule

// ----- src/dnle_front.sv -----
// ----------------------------------------------------------------------------
// Front: character intake
// Classifies each character, writes label characters into the current bank
// and queues a flush command when a label or the name ends.
// ----------------------------------------------------------------------------
module dnle_front
	import dnle_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_data,
	output ram_wr_t  wr,
	output logic     cmd_push,
	output cmd_t     cmd,
	input  logic     cmdq_full,
	input  release_t rel
);

	logic [BANKS-1:0]  busy_q;
	logic [BANK_W-1:0] bank_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              accept;
	logic              sep;
	logic              room;
	logic              flush;
	logic [CNT_W-1:0]  count_nx;
	logic              ovf_nx;

	assign full     = cmdq_full || busy_q[bank_q];
	assign accept   = push && !full;
	assign sep      = (in_data.in_char == CHAR_DOT) || (in_data.in_char == CHAR_NUL);
	assign room     = (count_q < CNT_W'(MAX_LABEL));
	assign flush    = sep || in_data.end_of_name;
	assign count_nx = count_q + CNT_W'(!sep && room);
	assign ovf_nx   = ovf_q || (!sep && !room);

	assign wr.en   = accept && !sep && room;
	assign wr.addr = {bank_q, count_q};
	assign wr.data = in_data.in_char;

	assign cmd_push = accept && flush && ((count_nx != '0) || in_data.end_of_name);
	assign cmd.len  = count_nx;
	assign cmd.ovf  = ovf_nx;
	assign cmd.last = in_data.end_of_name;
	assign cmd.bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			bank_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (accept) begin
				if (flush) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					if (count_nx != '0) begin
						busy_q[bank_q] <= 1'b1;
						bank_q         <= bank_q + 1'b1;
					end
				end else begin
					count_q <= count_nx;
					ovf_q   <= ovf_nx;
				end
			end
		end
	end

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (count_q < CNT_W'(MAX_LABEL)))
		else $error("label write beyond buffer");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy_q[bank_q])
		else $error("write into a bank still being read");

endmodule

// ----- src/dnle_back.sv -----
// ----------------------------------------------------------------------------
// Back: byte emitter
// Takes flush commands and sends the length byte, the label characters from
// the buffer and the closing zero through a one-entry output register.
// ----------------------------------------------------------------------------
module dnle_back
	import dnle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  cmd_t              cmd_head,
	output logic              cmd_pop,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output release_t          rel,
	output logic              empty,
	input  logic              pop,
	output out_item_t         out_data
);

	back_state_t      state_q;
	back_state_t      state_nx;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] idx_q;
	out_item_t        out_q;
	logic             out_valid_q;
	logic             out_free;
	logic             load;
	out_item_t        load_val;
	logic             last_char;

	assign out_free  = !out_valid_q || pop;
	assign last_char = (idx_q == cmd_q.len - 1'b1);
	assign empty     = !out_valid_q;
	assign out_data  = out_q;
	assign rd_addr   = {cmd_q.bank, idx_q};

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					if (cmd_head.len != '0) begin
						state_nx = S_LEN;
					end else begin
						state_nx = S_TERM;
					end
				end
			end
			S_LEN: begin
				if (out_free) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				state_nx = S_WR;
			end
			S_WR: begin
				if (out_free) begin
					if (!last_char) begin
						state_nx = S_RD;
					end else if (cmd_q.last) begin
						state_nx = S_TERM;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			S_TERM: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		rd_en     = 1'b0;
		load      = 1'b0;
		load_val  = '0;
		rel.valid = 1'b0;
		rel.bank  = cmd_q.bank;
		unique case (state_q)
			S_IDLE: begin
				cmd_pop = !cmd_empty;
			end
			S_LEN: begin
				load                    = out_free;
				load_val.out_byte       = 8'(cmd_q.len);
				load_val.label_too_long = cmd_q.ovf;
			end
			S_RD: begin
				rd_en = 1'b1;
			end
			S_WR: begin
				load              = out_free;
				load_val.out_byte = rd_data;
				rel.valid         = out_free && last_char;
			end
			S_TERM: begin
				load              = out_free;
				load_val.out_last = 1'b1;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		if (load) begin
			out_q <= load_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_LEN) begin
				idx_q <= '0;
			end else if (state_q == S_WR && out_free) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> (cmd_q.len != '0))
		else $error("length byte for an empty label");

	a_release_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> (state_q == S_WR) && (idx_q < cmd_q.len))
		else $error("bank released outside the character phase");

	a_term_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.out_last) |-> (out_q.out_byte == 8'd0) && !out_q.label_too_long)
		else $error("closing byte carries payload");

endmodule

// ----- src/dns_name_label_encoder.sv -----
// ----------------------------------------------------------------------------
// DNS name label encoder
// Turns a dotted host name, one character per transaction, into DNS wire
// format labels closed by a zero byte.
//
// Input channel: push with in_data, held off by full. A transaction is taken
// at a rising edge with push high and full low. Output channel: the oldest
// byte is on out_data while empty is low and is taken with pop.
// The front stores label characters in one of two buffer banks and queues a
// flush command at a dot, a zero character or the end of the name. The back
// reads the bank and emits the length byte after it picks up the command, then
// each character after its registered buffer read, then the closing zero after
// the last character of the name, or the closing zero alone when the name ends
// on an empty label.
// Input characters are taken one per cycle until both banks hold labels not
// yet sent or the two-entry command queue is full; the sustained rate is set
// by the back, which reads each character from the buffer before sending it.
// When pop stays low the output register holds its byte, the back waits and
// the front keeps filling until it runs out of banks or queue room.
// Reset clears all control state; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module dns_name_label_encoder
	import dnle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_data,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_data
);

	ram_wr_t           wr;
	logic              cmd_push;
	cmd_t              cmd_in;
	logic              cmdq_full;
	logic              cmdq_empty;
	logic              cmd_pop;
	cmd_t              cmd_head;
	release_t          rel;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	dnle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_data   (in_data),
		.wr        (wr),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmdq_full (cmdq_full),
		.rel       (rel)
	);

	dnle_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.q_full   (cmdq_full),
		.pop      (cmd_pop),
		.q_empty  (cmdq_empty),
		.head     (cmd_head)
	);

	dnle_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dnle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmdq_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.rel       (rel),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data)
	);

endmodule
